### hdl/integer_to_ascii_formatter_top_assert.svh
// Assertion macros shared by the checker of the integer formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITAF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer formatter check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer formatter check failed");

`endif

### hdl/itaf_pkg.sv
package itaf_pkg;

  // Width of every character count and position inside one field.
  localparam int CNT_W = 8;

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [3:0] MAX_DEC_DIGIT = 4'd9;
  localparam logic [3:0] DEC_TEN = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_CONV,
    ST_NORM,
    ST_SETUP1,
    ST_SETUP2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dd_step;
    logic norm_step;
    logic setup1;
    logic setup2;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic dd_last;
    logic norm_done;
    logic empty;
    logic at_last;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d <= MAX_DEC_DIGIT) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A + {4'd0, d - DEC_TEN};
    end
    return c;
  endfunction

endpackage

### hdl/integer_to_ascii_formatter_top.sv
// Formats one integer request into a printf-style field of ASCII characters,
// delivered one character per output transfer with last_char on the final
// one; a request that formats to nothing produces no output at all. Requests
// are handled one at a time. After acceptance the block chooses the radix
// path in ST_PICK; a decimal request then runs a shift-and-add-three binary
// to BCD converter over all VALUE_BITS bits, while octal and hexadecimal
// digits are taken straight from the bits. A digit normalizer then shifts
// leading zero digits out at one digit per cycle until the leading digit is
// nonzero or all places are shifted out; states ST_SETUP1 and ST_SETUP2
// then size the fill, sign and zero runs. Characters then leave at one per
// cycle while out_ready is high, and at most MAX_FIELD of them are sent;
// longer fields are cut there. The input side is ready again as soon as the
// last character sits in the output register, so the next request may be
// accepted while that character still waits to be taken.
module integer_to_ascii_formatter_top #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_FIELD  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       magnitude,
  input  logic              negative,
  input  logic [1:0]        radix_select,
  input  logic [6:0]        field_width,
  input  logic signed [6:0] digit_precision,
  input  logic              plus_flag,
  input  logic              space_flag,
  input  logic              zero_pad,
  input  logic              left_align,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              last_char
);

  // Commands from the sequencer and status from the datapath.
  itaf_pkg::ctl_cmd_t cmd;
  itaf_pkg::ctl_sts_t sts;

  // The sequencer walks pick, convert (decimal only), normalize, size and emit phases.
  itaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the captured request, the digit register and the
  // output register.
  itaf_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .magnitude       (magnitude),
    .negative        (negative),
    .radix_select    (radix_select),
    .field_width     (field_width),
    .digit_precision (digit_precision),
    .plus_flag       (plus_flag),
    .space_flag      (space_flag),
    .zero_pad        (zero_pad),
    .left_align      (left_align),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .last_char       (last_char)
  );

endmodule

### hdl/itaf_datapath.sv
module itaf_datapath #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_FIELD  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [63:0]            magnitude,
  input  logic                   negative,
  input  logic [1:0]             radix_select,
  input  logic [6:0]             field_width,
  input  logic signed [6:0]      digit_precision,
  input  logic                   plus_flag,
  input  logic                   space_flag,
  input  logic                   zero_pad,
  input  logic                   left_align,
  input  itaf_pkg::ctl_cmd_t     cmd,
  output itaf_pkg::ctl_sts_t     sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_char,
  output logic                   last_char
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int DW   = NDIG * 4;
  localparam int NCW  = $clog2(NDIG + 1);
  localparam int DDW  = $clog2(VALUE_BITS);
  localparam int CW   = itaf_pkg::CNT_W;

  logic [VALUE_BITS-1:0] bin;
  logic [DW-1:0]         digits;
  logic [DDW-1:0]        dd_cnt;
  logic [NCW-1:0]        shifts;
  logic [1:0]            radix;
  logic                  neg, plus, spc, zero, left;
  logic [6:0]            width;
  logic [6:0]            prec;
  logic                  has_sign;
  logic [7:0]            sign_ch;
  logic [CW-1:0]         body, dcnt, pcnt;
  logic [CW-1:0]         b1, b2, b3, b4, len, pos;

  logic [DW-1:0]         padded;
  logic [DW-1:0]         oct_digits, hex_digits, adj;
  logic [CW-1:0]         prec_eff, dcnt_calc, body_calc;
  logic                  sign_calc;
  logic [CW:0]           diff;
  logic [CW-1:0]         a_cnt, z_cnt, t_cnt, b2_c, b3_c, b4_c, total;
  logic [7:0]            ch;
  logic                  in_digits;

  always_comb begin
    padded = DW'(magnitude[VALUE_BITS-1:0]);
    for (int k = 0; k < NDIG; k++) begin
      oct_digits[4*k +: 4] = {1'b0, padded[3*k +: 3]};
      hex_digits[4*k +: 4] = padded[4*k +: 4];
      adj[4*k +: 4] = (digits[4*k +: 4] >= 4'd5) ? digits[4*k +: 4] + 4'd3
                                                  : digits[4*k +: 4];
    end
  end

  always_comb begin
    prec_eff  = prec[6] ? CW'(1) : CW'(prec);
    dcnt_calc = CW'(NDIG) - CW'(shifts);
    body_calc = (prec_eff > dcnt_calc) ? prec_eff : dcnt_calc;
    sign_calc = neg || plus || spc;
    diff      = (CW+1)'(width) - {1'b0, body_calc} - (CW+1)'(sign_calc);
    a_cnt = (!left && !zero) ? pcnt : '0;
    z_cnt = (!left && zero) ? pcnt : '0;
    t_cnt = left ? pcnt : '0;
    b2_c  = a_cnt + CW'(has_sign);
    b3_c  = b2_c + z_cnt + (body - dcnt);
    b4_c  = b3_c + dcnt;
    total = b4_c + t_cnt;
  end

  always_comb begin
    in_digits = (pos >= b3) && (pos < b4);
    if (pos < b1) begin
      ch = itaf_pkg::CH_SPACE;
    end else if (pos < b2) begin
      ch = sign_ch;
    end else if (pos < b3) begin
      ch = itaf_pkg::CH_ZERO;
    end else if (in_digits) begin
      ch = itaf_pkg::digit_to_ascii(digits[DW-1 -: 4]);
    end else begin
      ch = itaf_pkg::CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin    <= magnitude[VALUE_BITS-1:0];
      radix  <= radix_select;
      neg    <= negative;
      plus   <= plus_flag;
      spc    <= space_flag;
      zero   <= zero_pad;
      left   <= left_align;
      width  <= field_width;
      prec   <= digit_precision;
      dd_cnt <= '0;
      shifts <= '0;
      if (radix_select == itaf_pkg::RADIX_OCT) begin
        digits <= oct_digits;
      end else if (radix_select == itaf_pkg::RADIX_DEC) begin
        digits <= '0;
      end else begin
        digits <= hex_digits;
      end
    end
    if (cmd.dd_step) begin
      digits <= {adj[DW-2:0], bin[VALUE_BITS-1]};
      bin    <= {bin[VALUE_BITS-2:0], 1'b0};
      dd_cnt <= dd_cnt + DDW'(1);
    end
    if (cmd.norm_step) begin
      digits <= {digits[DW-5:0], 4'd0};
      shifts <= shifts + NCW'(1);
    end
    if (cmd.setup1) begin
      has_sign <= sign_calc;
      sign_ch  <= neg ? itaf_pkg::CH_MINUS :
                  plus ? itaf_pkg::CH_PLUS : itaf_pkg::CH_SPACE;
      dcnt     <= dcnt_calc;
      body     <= body_calc;
      pcnt     <= diff[CW] ? '0 : diff[CW-1:0];
    end
    if (cmd.setup2) begin
      b1  <= a_cnt;
      b2  <= b2_c;
      b3  <= b3_c;
      b4  <= b4_c;
      len <= (total > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : total;
      pos <= '0;
    end
    if (cmd.emit) begin
      out_char  <= ch;
      last_char <= sts.at_last;
      pos       <= pos + CW'(1);
      if (in_digits) begin
        digits <= {digits[DW-5:0], 4'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.is_dec    = (radix == itaf_pkg::RADIX_DEC);
    sts.dd_last   = (dd_cnt == DDW'(VALUE_BITS - 1));
    sts.norm_done = (digits[DW-1 -: 4] != 4'd0) || (shifts == NCW'(NDIG));
    sts.empty     = (len == '0);
    sts.at_last   = (pos == len - CW'(1));
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

### hdl/itaf_ctrl.sv
module itaf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  itaf_pkg::ctl_sts_t sts,
  output itaf_pkg::ctl_cmd_t cmd
);

  itaf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      itaf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = itaf_pkg::ST_PICK;
        end
      end
      itaf_pkg::ST_PICK: begin
        state_next = sts.is_dec ? itaf_pkg::ST_CONV : itaf_pkg::ST_NORM;
      end
      itaf_pkg::ST_CONV: begin
        cmd.dd_step = 1'b1;
        if (sts.dd_last) begin
          state_next = itaf_pkg::ST_NORM;
        end
      end
      itaf_pkg::ST_NORM: begin
        if (sts.norm_done) begin
          state_next = itaf_pkg::ST_SETUP1;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      itaf_pkg::ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_next = itaf_pkg::ST_SETUP2;
      end
      itaf_pkg::ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_next = itaf_pkg::ST_EMIT;
      end
      itaf_pkg::ST_EMIT: begin
        if (sts.empty) begin
          state_next = itaf_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.at_last) begin
            state_next = itaf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = itaf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/itaf_checker.sv
`include "integer_to_ascii_formatter_top_assert.svh"

module itaf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);

  // A stalled character stays offered.
  `ITAF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // A stalled character keeps its value.
  `ITAF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable({out_char, last_char}))

  // An accepted request keeps the input side busy in the next cycle.
  `ITAF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // While ready for a new request, any pending character ends the field.
  `ITAF_ASSERT_SAME(a_idle_only_last, clk, rst, in_ready && out_valid, last_char)

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .last_char (last_char)
);
